FILE: src/asc_pkg.sv
// Shared types and codes for the atlas slot cache.
package asc_pkg;

  localparam int MARK_W = 3;

  localparam logic [MARK_W-1:0] MK_NONE  = 3'b000;
  localparam logic [MARK_W-1:0] MK_BACK  = 3'b001;
  localparam logic [MARK_W-1:0] MK_FRONT = 3'b010;
  localparam logic [MARK_W-1:0] MK_REC   = 3'b100;

  localparam logic [1:0] RQ_LOOKUP = 2'd0;
  localparam logic [1:0] RQ_ALLOC  = 2'd1;
  localparam logic [1:0] RQ_EOF    = 2'd2;
  localparam logic [1:0] RQ_INVAL  = 2'd3;

  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_MISS  = 3'd1;
  localparam logic [2:0] ST_ALLOC = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [1:0] PL_KEEP  = 2'd0;
  localparam logic [1:0] PL_BACK  = 2'd1;
  localparam logic [1:0] PL_REC   = 2'd2;
  localparam logic [1:0] PL_FREE  = 2'd3;

  typedef struct packed {
    logic key_we;
    logic mark_we;
    logic stamp_we;
  } slot_we_t;

  typedef enum logic [2:0] {
    PH_LK_BACK,
    PH_LK_REC,
    PH_LK_FRONT,
    PH_AL_BACK,
    PH_AL_FRONT,
    PH_EOF
  } phase_t;

  typedef enum logic [17:0] {
    S_CLR    = 18'd1 << 0,
    S_IDLE   = 18'd1 << 1,
    S_F_RD   = 18'd1 << 2,
    S_F_EV   = 18'd1 << 3,
    S_F_DONE = 18'd1 << 4,
    S_POP_RD = 18'd1 << 5,
    S_POP_EV = 18'd1 << 6,
    S_E_RD   = 18'd1 << 7,
    S_E_EV   = 18'd1 << 8,
    S_P1_RD  = 18'd1 << 9,
    S_P1_EV  = 18'd1 << 10,
    S_P2_RD  = 18'd1 << 11,
    S_P2_EV  = 18'd1 << 12,
    S_I_RD   = 18'd1 << 13,
    S_I_EV   = 18'd1 << 14,
    S_DIV    = 18'd1 << 15,
    S_OUT    = 18'd1 << 16,
    S_SPARE  = 18'd1 << 17
  } state_t;

endpackage

FILE: src/atlas_slot_cache.sv
// Top level of the atlas slot cache: request sequencer, free stack and plan store.
//
//   channel | ports                                   | handshake
//   request | in_req_type, in_key                     | start & !busy
//   result  | out_status, out_slot_col, out_slot_row  | out_valid, one cycle
//
// Every slot scan visits one slot at a time, with a read state and then an
// evaluate state, through one read port of the slot store. A lookup or
// allocate runs up to three scans, an invalidate one, and an end of frame two
// passes over all slots plus one search scan for each slot used only last
// frame. A result then passes through the row split. After reset the block
// clears the marks and refills the free stack, with busy high. The receiver cannot stall.
module atlas_slot_cache #(
  parameter int SLOTS     = 256,
  parameter int ROW_SLOTS = 128,
  parameter int KEY_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_key,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [6:0]  out_slot_col,
  output logic        out_slot_row
);
  import asc_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] LAST = CW'(SLOTS - 1);

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       eo_r, eo_nxt;
  logic [CW-1:0]       fc_r, fc_nxt;
  logic [KEY_BITS-1:0] fkey_r, fkey_nxt;
  logic [MARK_W-1:0]   fmask_r, fmask_nxt;
  logic                found_r, found_nxt;
  logic [IW-1:0]       fslot_r, fslot_nxt;
  logic [IW-1:0]       s_r, s_nxt;
  logic [2:0]          status_r, status_nxt;
  logic                best_v_r, best_v_nxt;
  logic [IW-1:0]       best_r, best_nxt;
  logic [31:0]         best_stamp_r, best_stamp_nxt;
  logic [31:0]         frame_r, frame_nxt;
  logic [IW-1:0]       rem_r, rem_nxt;
  logic                rowbit_r, rowbit_nxt;

  logic [KEY_BITS+15:0] key_ext;
  logic [KEY_BITS-1:0]  in_key_m;

  logic [IW-1:0]       ss_raddr;
  logic [KEY_BITS-1:0] ss_key;
  logic [MARK_W-1:0]   ss_mark;
  logic [31:0]         ss_stamp;
  slot_we_t            ss_we;
  logic [IW-1:0]       ss_waddr;
  logic [KEY_BITS-1:0] ss_wkey;
  logic [MARK_W-1:0]   ss_wmark;

  logic [IW-1:0] fs_mem [SLOTS];
  logic [IW-1:0] fs_rd_r;
  logic          fs_we;
  logic [IW-1:0] fs_waddr, fs_wdata;
  logic [CW-1:0] fc_m1;

  logic [1:0]    plan_mem [SLOTS];
  logic [1:0]    plan_rd_r;
  logic          plan_we;
  logic [1:0]    plan_wdata;

  logic          key_hit;
  logic          push_ok;
  logic [IW+7:0] col_ext;

  assign key_ext  = {{KEY_BITS{1'b0}}, in_key};
  assign in_key_m = key_ext[KEY_BITS-1:0];
  assign ss_raddr = (state_r == S_P1_RD) ? eo_r[IW-1:0] : idx_r[IW-1:0];
  assign key_hit  = (ss_key == fkey_r);
  assign push_ok  = (fc_r < CW'(SLOTS));
  assign fc_m1    = fc_r - 1'b1;

  asc_slot_store #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS),
    .IW       (IW)
  ) u_store (
    .clk      (clk),
    .rd_addr  (ss_raddr),
    .rd_key   (ss_key),
    .rd_mark  (ss_mark),
    .rd_stamp (ss_stamp),
    .wr_en    (ss_we),
    .wr_addr  (ss_waddr),
    .wr_key   (ss_wkey),
    .wr_mark  (ss_wmark),
    .wr_stamp (frame_r)
  );

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    fs_rd_r <= fs_mem[fc_m1[IW-1:0]];
    if (plan_we) begin
      plan_mem[eo_r[IW-1:0]] <= plan_wdata;
    end
    plan_rd_r <= plan_mem[eo_r[IW-1:0]];
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    eo_nxt         = eo_r;
    fc_nxt         = fc_r;
    fkey_nxt       = fkey_r;
    fmask_nxt      = fmask_r;
    found_nxt      = found_r;
    fslot_nxt      = fslot_r;
    s_nxt          = s_r;
    status_nxt     = status_r;
    best_v_nxt     = best_v_r;
    best_nxt       = best_r;
    best_stamp_nxt = best_stamp_r;
    frame_nxt      = frame_r;
    rem_nxt        = rem_r;
    rowbit_nxt     = rowbit_r;
    ss_we          = '0;
    ss_waddr       = idx_r[IW-1:0];
    ss_wkey        = fkey_r;
    ss_wmark       = MK_NONE;
    fs_we          = 1'b0;
    fs_waddr       = fc_r[IW-1:0];
    fs_wdata       = idx_r[IW-1:0];
    plan_we        = 1'b0;
    plan_wdata     = PL_KEEP;

    unique case (state_r)
      S_CLR: begin
        ss_we.mark_we = 1'b1;
        fs_we         = 1'b1;
        fs_waddr      = idx_r[IW-1:0];
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          fkey_nxt = in_key_m;
          idx_nxt  = '0;
          eo_nxt   = '0;
          unique case (in_req_type)
            RQ_LOOKUP: begin
              fmask_nxt = MK_BACK;
              phase_nxt = PH_LK_BACK;
              state_nxt = S_F_RD;
            end
            RQ_ALLOC: begin
              fmask_nxt = MK_BACK;
              phase_nxt = PH_AL_BACK;
              state_nxt = S_F_RD;
            end
            RQ_EOF:   state_nxt = S_P1_RD;
            RQ_INVAL: state_nxt = S_I_RD;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_F_RD: state_nxt = S_F_EV;
      S_F_EV: begin
        if (((ss_mark & fmask_r) != MK_NONE) && key_hit) begin
          found_nxt = 1'b1;
          fslot_nxt = idx_r[IW-1:0];
          state_nxt = S_F_DONE;
        end else if (idx_r == LAST) begin
          found_nxt = 1'b0;
          state_nxt = S_F_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_F_RD;
        end
      end
      S_F_DONE: begin
        idx_nxt = '0;
        unique case (phase_r)
          PH_LK_BACK: begin
            state_nxt = S_F_RD;
            if (found_r) begin
              s_nxt     = fslot_r;
              fmask_nxt = MK_FRONT;
              phase_nxt = PH_LK_FRONT;
            end else begin
              fmask_nxt = MK_REC;
              phase_nxt = PH_LK_REC;
            end
          end
          PH_LK_REC: begin
            if (found_r) begin
              // Revive the recycled slot before checking for a front mark.
              ss_we.mark_we = 1'b1;
              ss_waddr      = fslot_r;
              ss_wmark      = MK_BACK;
              s_nxt         = fslot_r;
              fmask_nxt     = MK_FRONT;
              phase_nxt     = PH_LK_FRONT;
              state_nxt     = S_F_RD;
            end else begin
              status_nxt = ST_MISS;
              rem_nxt    = '0;
              rowbit_nxt = 1'b0;
              state_nxt  = S_DIV;
            end
          end
          PH_LK_FRONT: begin
            if (!found_r) begin
              ss_we.mark_we = 1'b1;
              ss_waddr      = s_r;
              ss_wmark      = MK_BACK | MK_FRONT;
            end
            status_nxt = ST_HIT;
            rem_nxt    = s_r;
            rowbit_nxt = 1'b0;
            state_nxt  = S_DIV;
          end
          PH_AL_BACK: begin
            if (found_r) begin
              status_nxt = ST_ALLOC;
              rem_nxt    = fslot_r;
              rowbit_nxt = 1'b0;
              state_nxt  = S_DIV;
            end else begin
              fmask_nxt = MK_FRONT;
              phase_nxt = PH_AL_FRONT;
              state_nxt = S_F_RD;
            end
          end
          PH_AL_FRONT: begin
            if (found_r) begin
              status_nxt = ST_ALLOC;
              rem_nxt    = fslot_r;
              rowbit_nxt = 1'b0;
              state_nxt  = S_DIV;
            end else if (fc_r != '0) begin
              state_nxt = S_POP_RD;
            end else begin
              best_v_nxt = 1'b0;
              state_nxt  = S_E_RD;
            end
          end
          PH_EOF: begin
            plan_we    = 1'b1;
            plan_wdata = found_r ? PL_FREE : PL_REC;
            if (eo_r == LAST) begin
              eo_nxt    = '0;
              state_nxt = S_P2_RD;
            end else begin
              eo_nxt    = eo_r + 1'b1;
              state_nxt = S_P1_RD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_POP_RD: state_nxt = S_POP_EV;
      S_POP_EV: begin
        fc_nxt        = fc_m1;
        ss_we.key_we  = 1'b1;
        ss_we.mark_we = 1'b1;
        ss_waddr      = fs_rd_r;
        ss_wmark      = MK_FRONT;
        status_nxt    = ST_ALLOC;
        rem_nxt       = fs_rd_r;
        rowbit_nxt    = 1'b0;
        state_nxt     = S_DIV;
      end
      S_E_RD: state_nxt = S_E_EV;
      S_E_EV: begin
        if (((ss_mark & MK_REC) != MK_NONE) && (!best_v_r || (ss_stamp < best_stamp_r))) begin
          best_v_nxt     = 1'b1;
          best_nxt       = idx_r[IW-1:0];
          best_stamp_nxt = ss_stamp;
        end
        if (idx_r == LAST) begin
          rowbit_nxt = 1'b0;
          state_nxt  = S_DIV;
          if (best_v_nxt) begin
            ss_we.key_we  = 1'b1;
            ss_we.mark_we = 1'b1;
            ss_waddr      = best_nxt;
            ss_wmark      = MK_FRONT;
            status_nxt    = ST_ALLOC;
            rem_nxt       = best_nxt;
          end else begin
            status_nxt = ST_FULL;
            rem_nxt    = '0;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_E_RD;
        end
      end
      S_P1_RD: state_nxt = S_P1_EV;
      S_P1_EV: begin
        if ((ss_mark & MK_FRONT) == MK_NONE && (ss_mark & MK_BACK) != MK_NONE) begin
          // A slot used only last frame needs a search for its key.
          fkey_nxt  = ss_key;
          fmask_nxt = MK_FRONT | MK_REC;
          phase_nxt = PH_EOF;
          idx_nxt   = '0;
          state_nxt = S_F_RD;
        end else begin
          plan_we    = 1'b1;
          plan_wdata = ((ss_mark & MK_FRONT) != MK_NONE) ? PL_BACK : PL_KEEP;
          if (eo_r == LAST) begin
            eo_nxt    = '0;
            state_nxt = S_P2_RD;
          end else begin
            eo_nxt    = eo_r + 1'b1;
            state_nxt = S_P1_RD;
          end
        end
      end
      S_P2_RD: state_nxt = S_P2_EV;
      S_P2_EV: begin
        ss_waddr = eo_r[IW-1:0];
        case (plan_rd_r)
          PL_BACK: begin
            ss_we.mark_we = 1'b1;
            ss_wmark      = MK_BACK;
          end
          PL_REC: begin
            ss_we.mark_we  = 1'b1;
            ss_we.stamp_we = 1'b1;
            ss_wmark       = MK_REC;
          end
          PL_FREE: begin
            ss_we.mark_we = 1'b1;
            ss_wmark      = MK_NONE;
            fs_wdata      = eo_r[IW-1:0];
            if (push_ok) begin
              fs_we  = 1'b1;
              fc_nxt = fc_r + 1'b1;
            end
          end
          default: ;
        endcase
        if (eo_r == LAST) begin
          frame_nxt  = frame_r + 32'd1;
          status_nxt = ST_DONE;
          rem_nxt    = '0;
          rowbit_nxt = 1'b0;
          state_nxt  = S_DIV;
        end else begin
          eo_nxt    = eo_r + 1'b1;
          state_nxt = S_P2_RD;
        end
      end
      S_I_RD: state_nxt = S_I_EV;
      S_I_EV: begin
        if ((ss_mark != MK_NONE) && key_hit) begin
          ss_we.mark_we = 1'b1;
          ss_wmark      = MK_NONE;
          if (push_ok) begin
            fs_we  = 1'b1;
            fc_nxt = fc_r + 1'b1;
          end
        end
        if (idx_r == LAST) begin
          status_nxt = ST_DONE;
          rem_nxt    = '0;
          rowbit_nxt = 1'b0;
          state_nxt  = S_DIV;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_I_RD;
        end
      end
      S_DIV: begin
        // Split the slot index into row and column by repeated subtraction.
        if ({{(32-IW){1'b0}}, rem_r} >= 32'(ROW_SLOTS)) begin
          rem_nxt    = rem_r - IW'(ROW_SLOTS);
          rowbit_nxt = ~rowbit_r;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r   <= '0;
      fc_r    <= CW'(SLOTS);
      frame_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      fc_r    <= fc_nxt;
      frame_r <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r      <= phase_nxt;
    eo_r         <= eo_nxt;
    fkey_r       <= fkey_nxt;
    fmask_r      <= fmask_nxt;
    found_r      <= found_nxt;
    fslot_r      <= fslot_nxt;
    s_r          <= s_nxt;
    status_r     <= status_nxt;
    best_v_r     <= best_v_nxt;
    best_r       <= best_nxt;
    best_stamp_r <= best_stamp_nxt;
    rem_r        <= rem_nxt;
    rowbit_r     <= rowbit_nxt;
  end

  assign col_ext      = {8'd0, rem_r};
  assign busy         = (state_r != S_IDLE);
  assign out_valid    = (state_r == S_OUT);
  assign out_status   = status_r;
  assign out_slot_col = col_ext[6:0];
  assign out_slot_row = rowbit_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CW'(SLOTS))
    else $error("free stack count above slot count");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_MISS || out_status == ST_FULL ||
                   out_status == ST_DONE)) |-> (out_slot_col == 7'd0 && !out_slot_row))
    else $error("slot position reported without a slot");

endmodule

FILE: src/asc_slot_store.sv
// Per-slot key, mark and stamp memories with one registered read port.
module asc_slot_store #(
  parameter int SLOTS    = 256,
  parameter int KEY_BITS = 16,
  parameter int IW       = 8
) (
  input  logic                    clk,
  input  logic [IW-1:0]           rd_addr,
  output logic [KEY_BITS-1:0]     rd_key,
  output logic [asc_pkg::MARK_W-1:0] rd_mark,
  output logic [31:0]             rd_stamp,
  input  asc_pkg::slot_we_t       wr_en,
  input  logic [IW-1:0]           wr_addr,
  input  logic [KEY_BITS-1:0]     wr_key,
  input  logic [asc_pkg::MARK_W-1:0] wr_mark,
  input  logic [31:0]             wr_stamp
);
  import asc_pkg::*;

  logic [KEY_BITS-1:0] key_mem   [SLOTS];
  logic [MARK_W-1:0]   mark_mem  [SLOTS];
  logic [31:0]         stamp_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_en.mark_we) begin
      mark_mem[wr_addr] <= wr_mark;
    end
    if (wr_en.stamp_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    rd_key   <= key_mem[rd_addr];
    rd_mark  <= mark_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
  end

endmodule

FILE: sim/tb_top.sv
// Testbench for the atlas slot cache: random and directed requests checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  import asc_pkg::*;

  localparam int NSLOTS = 256;
  localparam int ROWW   = 128;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] key;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] col;
    logic       row;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = RQ_LOOKUP;
  logic [15:0] in_key = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [6:0] out_slot_col;
  logic out_slot_row;

  atlas_slot_cache dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_key(in_key), .out_valid(out_valid),
    .out_status(out_status), .out_slot_col(out_slot_col), .out_slot_row(out_slot_row)
  );

  always #5 clk = ~clk;

  // Shadow copy of the slot store.
  logic [15:0] sh_keys [NSLOTS];
  logic [2:0]  sh_marks [NSLOTS];
  logic [31:0] sh_stamps [NSLOTS];
  int          sh_free [NSLOTS];
  int          sh_free_cnt;
  logic [31:0] sh_frame;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  int mismatches = 0;
  int gap = 0;
  bit stim_done = 0;

  // Busy as seen at the last rising edge, so the driver knows if its start was taken.
  logic busy_q = 1'b1;

  function automatic void add_req(request_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void add_reply(reply_t e);
    expected_replies = {expected_replies, e};
  endfunction

  function automatic int find_slot(logic [15:0] k, logic [2:0] m);
    for (int s = 0; s < NSLOTS; s++)
      if ((sh_marks[s] & m) != 0 && sh_keys[s] == k) return s;
    return -1;
  endfunction

  function automatic void free_slot(int s);
    sh_marks[s] = MK_NONE;
    if (sh_free_cnt < NSLOTS) begin
      sh_free[sh_free_cnt] = s;
      sh_free_cnt++;
    end
  endfunction

  function automatic void mark_front_once(int s, logic [15:0] k);
    if (find_slot(k, MK_FRONT) < 0) sh_marks[s] |= MK_FRONT;
  endfunction

  function automatic int grab_slot(logic [15:0] k);
    int s;
    int best;
    s = find_slot(k, MK_BACK);
    if (s >= 0) return s;
    s = find_slot(k, MK_FRONT);
    if (s >= 0) return s;
    if (sh_free_cnt > 0) begin
      sh_free_cnt--;
      s = sh_free[sh_free_cnt];
      sh_keys[s] = k;
      sh_marks[s] = MK_FRONT;
      return s;
    end
    best = -1;
    for (s = 0; s < NSLOTS; s++)
      if ((sh_marks[s] & MK_REC) != 0 && (best < 0 || sh_stamps[s] < sh_stamps[best]))
        best = s;
    if (best >= 0) begin
      sh_keys[best] = k;
      sh_marks[best] = MK_FRONT;
    end
    return best;
  endfunction

  function automatic void close_frame();
    logic [1:0] plan [NSLOTS];
    for (int s = 0; s < NSLOTS; s++) begin
      plan[s] = PL_KEEP;
      if ((sh_marks[s] & MK_FRONT) != 0) plan[s] = PL_BACK;
      else if ((sh_marks[s] & MK_BACK) != 0) begin
        if (find_slot(sh_keys[s], MK_FRONT) >= 0 || find_slot(sh_keys[s], MK_REC) >= 0)
          plan[s] = PL_FREE;
        else
          plan[s] = PL_REC;
      end
    end
    for (int s = 0; s < NSLOTS; s++) begin
      if (plan[s] == PL_BACK) sh_marks[s] = MK_BACK;
      else if (plan[s] == PL_REC) begin
        sh_marks[s] = MK_REC;
        sh_stamps[s] = sh_frame;
      end else if (plan[s] == PL_FREE) free_slot(s);
    end
    sh_frame++;
  endfunction

  function automatic reply_t serve_request(request_t r);
    reply_t rep;
    int s;
    s = -1;
    rep.status = ST_DONE;
    case (r.req)
      RQ_LOOKUP: begin
        s = find_slot(r.key, MK_BACK);
        if (s >= 0) begin
          mark_front_once(s, r.key);
          rep.status = ST_HIT;
        end else begin
          s = find_slot(r.key, MK_REC);
          if (s >= 0) begin
            sh_marks[s] = MK_BACK;
            mark_front_once(s, r.key);
            rep.status = ST_HIT;
          end else rep.status = ST_MISS;
        end
      end
      RQ_ALLOC: begin
        s = grab_slot(r.key);
        rep.status = (s >= 0) ? ST_ALLOC : ST_FULL;
      end
      RQ_EOF: close_frame();
      default: begin
        for (int t = 0; t < NSLOTS; t++)
          if (sh_marks[t] != MK_NONE && sh_keys[t] == r.key) free_slot(t);
      end
    endcase
    if (s >= 0 && (rep.status == ST_HIT || rep.status == ST_ALLOC)) begin
      rep.col = 7'(s % ROWW);
      rep.row = 1'(s / ROWW);
    end else begin
      rep.col = '0;
      rep.row = 1'b0;
    end
    return rep;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] pick_key();
    int p;
    p = $urandom_range(0, 9);
    if (p < 8) return 16'($urandom_range(0, 23));
    if (p == 8) return 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
    return 16'($urandom);
  endfunction

  // Driver: a transaction is taken at a rising edge with start high and busy low.
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !busy_q) begin
        start <= 1'b0;
        gap = pick_gap();
      end else if (!start) begin
        if (gap > 0) gap--;
        else if (pending_reqs.size() > 0) begin
          request_t r;
          r = pending_reqs.pop_front();
          in_req_type <= r.req;
          in_key <= r.key;
          start <= 1'b1;
          add_reply(serve_request(r));
        end
      end
    end
  end

  always @(posedge clk) busy_q <= busy;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transaction: status %0d", out_status);
      end else begin
        reply_t e;
        e = expected_replies.pop_front();
        if (e.status !== out_status || e.col !== out_slot_col || e.row !== out_slot_row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected status %0d col %0d row %0d, got %0d %0d %0d",
                     e.status, e.col, e.row, out_status, out_slot_col, out_slot_row);
        end
      end
    end
  end

  initial begin
    request_t r;
    int p;
    for (int s = 0; s < NSLOTS; s++) begin
      sh_keys[s] = '0;
      sh_marks[s] = MK_NONE;
      sh_stamps[s] = '0;
      sh_free[s] = s;
    end
    sh_free_cnt = NSLOTS;
    sh_frame = '0;

    // Directed: miss, allocate, hit, reuse, frame turns, revive, invalidate, extremes.
    add_req('{RQ_LOOKUP, 16'h0000});
    add_req('{RQ_ALLOC, 16'h0000});
    add_req('{RQ_ALLOC, 16'hFFFF});
    add_req('{RQ_ALLOC, 16'h0000});
    add_req('{RQ_LOOKUP, 16'h0000});
    add_req('{RQ_EOF, 16'h0000});
    add_req('{RQ_LOOKUP, 16'hFFFF});
    add_req('{RQ_EOF, 16'hFFFF});
    add_req('{RQ_LOOKUP, 16'h0000});
    add_req('{RQ_ALLOC, 16'h0000});
    add_req('{RQ_EOF, 16'h0000});
    add_req('{RQ_INVAL, 16'hFFFF});
    add_req('{RQ_INVAL, 16'h1234});
    add_req('{RQ_LOOKUP, 16'hFFFF});
    // Fill every slot, then force full and eviction paths.
    for (int i = 0; i < 260; i++) add_req('{RQ_ALLOC, 16'(16'h8000 + i)});
    add_req('{RQ_EOF, 16'h0000});
    add_req('{RQ_EOF, 16'h0000});
    add_req('{RQ_ALLOC, 16'h7777});
    add_req('{RQ_ALLOC, 16'h7778});
    add_req('{RQ_LOOKUP, 16'h8005});

    for (int i = 0; i < 1220; i++) begin
      p = $urandom_range(0, 99);
      if (p < 35) r.req = RQ_LOOKUP;
      else if (p < 75) r.req = RQ_ALLOC;
      else if (p < 90) r.req = RQ_EOF;
      else r.req = RQ_INVAL;
      r.key = pick_key();
      add_req(r);
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_replies.size() == 0);
    repeat (3000) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // An end of frame with every slot used only last frame is the longest request;
  // the timeout allows several times its length for every item.
  initial begin
    repeat (1000) #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
src/asc_pkg.sv
src/asc_slot_store.sv
src/atlas_slot_cache.sv
sim/tb_top.sv
